// ===== src/slrp_pkg.sv =====
// Package of shared types and constants for the sensor log record parser.
package slrp_pkg;

	// Record layout
	localparam int RecLen = 30;
	localparam int PosW = 5;
	localparam int NumDtFields = 5;
	localparam int GrpW = 3;
	localparam logic [PosW-1:0] LastPos = PosW'(RecLen - 1);

	// Field widths
	localparam int YearW = 14;
	localparam int TwoDigW = 7;
	localparam int BattW = 13;
	localparam int WordW = 16;
	localparam int OutDataW = 96;

	// Battery byte scale factor
	localparam logic [4:0] BatteryScale = 5'd30;

	// What one character position does
	typedef enum logic [2:0] {
		K_YEAR_FIRST,
		K_YEAR_NEXT,
		K_DT_FIRST,
		K_DT_SECOND,
		K_HEX_FIRST,
		K_HEX_NEXT,
		K_SKIP
	} pos_kind_t;

	// Decoded character and position class
	typedef struct packed {
		logic [3:0]       dec_val;
		logic [3:0]       hex_val;
		pos_kind_t        kind;
		logic [GrpW-1:0]  grp;
		logic [PosW-1:0]  pos;
	} char_info_t;

	// One parsed record
	typedef struct packed {
		logic [YearW-1:0]   year;
		logic [TwoDigW-1:0] month;
		logic [TwoDigW-1:0] day;
		logic [TwoDigW-1:0] hour;
		logic [TwoDigW-1:0] minute;
		logic [TwoDigW-1:0] second;
		logic [BattW-1:0]   battery_level;
		logic [WordW-1:0]   temperature_tenths;
		logic [WordW-1:0]   humidity_tenths;
	} record_t;

	// Status from the accumulator to the top level
	typedef struct packed {
		logic            fire;
		logic [PosW-1:0] position;
	} acc_status_t;

endpackage

// ===== src/slrp_char_decode.sv =====
// Character and position decoder of the sensor log record parser.
module slrp_char_decode (
	input  logic [7:0]                 char_code,
	input  logic                       line_start,
	input  logic [slrp_pkg::PosW-1:0]  position_q,
	output slrp_pkg::char_info_t       info
);

	logic [slrp_pkg::PosW-1:0] pos;

	// Realignment forces the current character to the first position.
	assign pos = line_start ? '0 : position_q;

	// Digit values and position class of the current character.
	always_comb begin
		// Decimal and hex digit values; anything else counts as zero.
		info.dec_val = 4'd0;
		info.hex_val = 4'd0;
		if (char_code >= 8'h30 && char_code <= 8'h39) begin
			info.dec_val = 4'(char_code - 8'h30);
			info.hex_val = 4'(char_code - 8'h30);
		end else if (char_code >= 8'h61 && char_code <= 8'h66) begin
			info.hex_val = 4'(char_code - 8'h57);
		end else if (char_code >= 8'h41 && char_code <= 8'h46) begin
			info.hex_val = 4'(char_code - 8'h37);
		end

		// Position class: digit groups, separators and hex groups.
		info.pos = pos;
		info.grp = '0;
		unique case (pos)
			5'd0: info.kind = slrp_pkg::K_YEAR_FIRST;
			5'd1, 5'd2, 5'd3: info.kind = slrp_pkg::K_YEAR_NEXT;
			5'd5: begin info.kind = slrp_pkg::K_DT_FIRST; info.grp = 3'd0; end
			5'd6: begin info.kind = slrp_pkg::K_DT_SECOND; info.grp = 3'd0; end
			5'd8: begin info.kind = slrp_pkg::K_DT_FIRST; info.grp = 3'd1; end
			5'd9: begin info.kind = slrp_pkg::K_DT_SECOND; info.grp = 3'd1; end
			5'd11: begin info.kind = slrp_pkg::K_DT_FIRST; info.grp = 3'd2; end
			5'd12: begin info.kind = slrp_pkg::K_DT_SECOND; info.grp = 3'd2; end
			5'd14: begin info.kind = slrp_pkg::K_DT_FIRST; info.grp = 3'd3; end
			5'd15: begin info.kind = slrp_pkg::K_DT_SECOND; info.grp = 3'd3; end
			5'd17: begin info.kind = slrp_pkg::K_DT_FIRST; info.grp = 3'd4; end
			5'd18: begin info.kind = slrp_pkg::K_DT_SECOND; info.grp = 3'd4; end
			5'd20, 5'd22, 5'd26: info.kind = slrp_pkg::K_HEX_FIRST;
			5'd21, 5'd23, 5'd24, 5'd25, 5'd27, 5'd28, 5'd29:
				info.kind = slrp_pkg::K_HEX_NEXT;
			default: info.kind = slrp_pkg::K_SKIP;
		endcase
	end

endmodule

// ===== src/slrp_field_acc.sv =====
// Field accumulators and record assembly of the sensor log record parser.
module slrp_field_acc (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	input  slrp_pkg::char_info_t     info,
	output logic [slrp_pkg::PosW-1:0] position_q,
	output slrp_pkg::acc_status_t    status,
	output slrp_pkg::record_t        rec
);

	logic [slrp_pkg::YearW-1:0]   year_acc_q;
	logic [3:0]                   two_digit_acc_q;
	logic [slrp_pkg::TwoDigW-1:0] dt_fields_q [slrp_pkg::NumDtFields];
	logic [slrp_pkg::WordW-1:0]   hex_acc_q;
	logic [slrp_pkg::BattW-1:0]   battery_q;
	logic [slrp_pkg::WordW-1:0]   temperature_q;

	logic [slrp_pkg::YearW-1:0]   year_next;
	logic [slrp_pkg::TwoDigW-1:0] two_digit_val;
	logic [slrp_pkg::WordW-1:0]   hex_next;
	logic [slrp_pkg::BattW-1:0]   battery_next;

	// Next values of the accumulators for the current character.
	assign year_next = (info.kind == slrp_pkg::K_YEAR_FIRST)
		? slrp_pkg::YearW'(info.dec_val)
		: slrp_pkg::YearW'({year_acc_q, 3'b000} + {year_acc_q, 1'b0}
			+ slrp_pkg::YearW'(info.dec_val));
	assign two_digit_val = slrp_pkg::TwoDigW'({two_digit_acc_q, 3'b000}
		+ {two_digit_acc_q, 1'b0} + info.dec_val);
	assign hex_next = (info.kind == slrp_pkg::K_HEX_FIRST)
		? slrp_pkg::WordW'(info.hex_val)
		: {hex_acc_q[slrp_pkg::WordW-5:0], info.hex_val};
	// The battery byte never exceeds eight bits, since its group starts with a load.
	assign battery_next = slrp_pkg::BattW'(hex_next[7:0] * slrp_pkg::BatteryScale);

	// The record completes on the last hex digit.
	assign status.fire = accept && (info.pos == slrp_pkg::LastPos);
	assign status.position = position_q;

	// Parser state, updated on each accepted transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			year_acc_q <= '0;
			two_digit_acc_q <= '0;
			for (int k = 0; k < slrp_pkg::NumDtFields; k++) dt_fields_q[k] <= '0;
			hex_acc_q <= '0;
			battery_q <= '0;
			temperature_q <= '0;
		end else if (accept) begin
			position_q <= (info.pos >= slrp_pkg::LastPos) ? '0 : info.pos + 1'b1;
			unique case (info.kind)
				slrp_pkg::K_YEAR_FIRST, slrp_pkg::K_YEAR_NEXT: year_acc_q <= year_next;
				slrp_pkg::K_DT_FIRST: two_digit_acc_q <= info.dec_val;
				slrp_pkg::K_DT_SECOND: dt_fields_q[info.grp] <= two_digit_val;
				slrp_pkg::K_HEX_FIRST, slrp_pkg::K_HEX_NEXT: begin
					hex_acc_q <= hex_next;
					if (info.pos == 5'd21) battery_q <= battery_next;
					if (info.pos == 5'd25) temperature_q <= hex_next;
				end
				slrp_pkg::K_SKIP: ;
				default: ;
			endcase
		end
	end

	// Record as it stands, with the current character applied to the humidity word.
	always_comb begin
		rec.year = year_acc_q;
		rec.month = dt_fields_q[0];
		rec.day = dt_fields_q[1];
		rec.hour = dt_fields_q[2];
		rec.minute = dt_fields_q[3];
		rec.second = dt_fields_q[4];
		rec.battery_level = battery_q;
		rec.temperature_tenths = temperature_q;
		rec.humidity_tenths = hex_next;
	end

endmodule

// ===== src/sensor_log_record_parser.sv =====
// Top level of the sensor log record parser: stream ports and result register.
//
// The block takes one ASCII character per transfer on the slave stream and
// parses fixed 30-character records "YYYY-MM-DDThh:mm:ss BBTTTTHHHH".
// s_tuser high marks the first character of a record and realigns parsing.
// Records may also follow one another without the marker.
// After the 30th character one parsed record appears on the master stream
// in the next cycle, held in a result register until the receiver takes it.
// A new character is accepted every cycle while s_tready is high, one per
// cycle sustained; the rate is set by the decode and accumulate path.
// While a result waits and m_tready is low, s_tready drops, so characters
// stall only while the result register is full and not being drained.
// Reset clears the position and all accumulators and empties the result
// register. Decimal positions treat non-digits as zero, hex positions treat
// non-hex characters as zero, and separator positions are ignored.
module sensor_log_record_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] char_code
	input  logic        s_tuser,  // [0] line_start
	output logic        m_tvalid,
	input  logic        m_tready,
	// [13:0] year, [20:14] month, [27:21] day, [34:28] hour, [41:35] minute,
	// [48:42] second, [61:49] battery_level, [77:62] temperature_tenths,
	// [93:78] humidity_tenths, [95:94] zero
	output logic [95:0] m_tdata
);

	logic                      accept;
	logic [slrp_pkg::PosW-1:0] position_q;
	slrp_pkg::char_info_t      info;
	slrp_pkg::acc_status_t     status;
	slrp_pkg::record_t         rec;
	logic                      out_valid_q;
	logic [slrp_pkg::OutDataW-1:0] out_data_q;

	// Input transfer takes place when the result register can take a record.
	assign s_tready = !out_valid_q || m_tready;
	assign accept = s_tvalid && s_tready;

	slrp_char_decode u_decode (
		.char_code (s_tdata),
		.line_start(s_tuser),
		.position_q(position_q),
		.info      (info)
	);

	slrp_field_acc u_acc (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.info      (info),
		.position_q(position_q),
		.status    (status),
		.rec       (rec)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (status.fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (status.fire) begin
			out_data_q <= {2'b00, rec.humidity_tenths, rec.temperature_tenths,
				rec.battery_level, rec.second, rec.minute, rec.hour, rec.day,
				rec.month, rec.year};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

	// The position never leaves the record.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		status.position <= slrp_pkg::LastPos)
		else $error("position out of record range");

	// A completed record shows up next cycle and parsing wraps to the start.
	a_fire_out: assert property (@(posedge clk) disable iff (!arst_n)
		status.fire |=> (m_tvalid && status.position == '0))
		else $error("completed record not presented");

	// A realigning character is always taken as the first position.
	a_realign: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser) |=> (status.position == 5'd1))
		else $error("line start did not realign position");

endmodule

// ===== bench/tb_sensor_log_record_parser.sv =====
`timescale 1ns / 100ps
// Testbench for the sensor log record parser: record stimulus, prediction and checking.
module tb_sensor_log_record_parser;

	localparam int IdleLimit   = 2000;
	localparam int TailCycles  = 10;
	localparam int RandomChars = 620;
	localparam int StallCycles = 150;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [7:0]          s_tdata;  // [7:0] char_code
	logic                s_tuser;  // [0] line_start
	logic                m_tvalid;
	logic                m_tready;
	// [13:0] year, [20:14] month, [27:21] day, [34:28] hour, [41:35] minute,
	// [48:42] second, [61:49] battery_level, [77:62] temperature_tenths,
	// [93:78] humidity_tenths, [95:94] zero
	logic [slrp_pkg::OutDataW-1:0] m_tdata;

	// Predicted parser state
	logic [slrp_pkg::PosW-1:0]    cur_pos = '0;
	logic [slrp_pkg::YearW-1:0]   year_sum = '0;
	logic [slrp_pkg::TwoDigW-1:0] first_digit = '0;
	logic [slrp_pkg::TwoDigW-1:0] dt_value [slrp_pkg::NumDtFields] = '{default: '0};
	logic [slrp_pkg::WordW-1:0]   hex_word = '0;
	logic [slrp_pkg::BattW-1:0]   battery_scaled = '0;
	logic [slrp_pkg::WordW-1:0]   temperature_word = '0;

	// Records still awaited on the output stream, oldest first
	slrp_pkg::record_t expected_records [$];

	// Characters of the record being sent
	logic [7:0] rec_buf [slrp_pkg::RecLen];

	bit tx_idle_en = 1'b0;
	bit rx_idle_en = 1'b0;
	int rx_hold_cycles = 0;
	int error_count = 0;
	int chars_sent = 0;
	int line_starts = 0;
	int records_checked = 0;
	int idle_cycles = 0;

	sensor_log_record_parser u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// 10 ns clock.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// End the run if no transfer happens on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IdleLimit) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	task automatic report_error(input string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic compare_field(input string name, input int got, input int want);
		if (got != want) begin
			report_error($sformatf("record %0d %s: got %0d, expected %0d",
				records_checked, name, got, want));
		end
	endtask

	// Advance the predicted parser by one character; queue a record at the last position.
	function automatic void parse_char(input logic [7:0] code, input logic first);
		int p;
		int d;
		int h;
		slrp_pkg::pos_kind_t kind;
		slrp_pkg::record_t rec;
		p = first ? 0 : int'(cur_pos);
		if (p >= slrp_pkg::RecLen) begin
			p = 0;
		end
		// Non-digits count as zero in both number bases.
		d = (code >= 8'h30 && code <= 8'h39) ? int'(code) - 8'h30 : 0;
		if (code >= 8'h30 && code <= 8'h39) begin
			h = int'(code) - 8'h30;
		end else if (code >= 8'h61 && code <= 8'h66) begin
			h = int'(code) - 8'h61 + 10;
		end else if (code >= 8'h41 && code <= 8'h46) begin
			h = int'(code) - 8'h41 + 10;
		end else begin
			h = 0;
		end
		// Classify the position; separators fall through as skipped.
		if (p == 0) begin
			kind = slrp_pkg::K_YEAR_FIRST;
		end else if (p < 4) begin
			kind = slrp_pkg::K_YEAR_NEXT;
		end else if (p >= 5 && p <= 18) begin
			case ((p - 5) % 3)
				0: kind = slrp_pkg::K_DT_FIRST;
				1: kind = slrp_pkg::K_DT_SECOND;
				default: kind = slrp_pkg::K_SKIP;
			endcase
		end else if (p == 20 || p == 22 || p == 26) begin
			kind = slrp_pkg::K_HEX_FIRST;
		end else if (p > 20) begin
			kind = slrp_pkg::K_HEX_NEXT;
		end else begin
			kind = slrp_pkg::K_SKIP;
		end
		case (kind)
			slrp_pkg::K_YEAR_FIRST: year_sum = slrp_pkg::YearW'(d);
			slrp_pkg::K_YEAR_NEXT:
				year_sum = slrp_pkg::YearW'(int'(year_sum) * 10 + d);
			slrp_pkg::K_DT_FIRST: first_digit = slrp_pkg::TwoDigW'(d);
			slrp_pkg::K_DT_SECOND:
				dt_value[(p - 5) / 3] = slrp_pkg::TwoDigW'(int'(first_digit) * 10 + d);
			slrp_pkg::K_HEX_FIRST: hex_word = slrp_pkg::WordW'(h);
			slrp_pkg::K_HEX_NEXT:
				hex_word = slrp_pkg::WordW'((int'(hex_word) << 4) | h);
			default: ;
		endcase
		// Store the finished hex groups and emit the record at the end.
		if (p == 21) begin
			battery_scaled = slrp_pkg::BattW'(int'(hex_word) * int'(slrp_pkg::BatteryScale));
		end else if (p == 25) begin
			temperature_word = hex_word;
		end else if (p == slrp_pkg::RecLen - 1) begin
			rec.year = year_sum;
			rec.month = dt_value[0];
			rec.day = dt_value[1];
			rec.hour = dt_value[2];
			rec.minute = dt_value[3];
			rec.second = dt_value[4];
			rec.battery_level = battery_scaled;
			rec.temperature_tenths = temperature_word;
			rec.humidity_tenths = hex_word;
			expected_records.insert(expected_records.size(), rec);
		end
		cur_pos = (p + 1 >= slrp_pkg::RecLen) ? '0 : slrp_pkg::PosW'(p + 1);
	endfunction

	// Offer one character and wait for its transfer.
	task automatic send_char(input logic [7:0] code, input logic first);
		int gap;
		gap = tx_idle_en ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= code;
		s_tuser <= first;
		do @(posedge clk); while (!s_tready);
		parse_char(code, first);
		chars_sent++;
		if (first) begin
			line_starts++;
		end
	endtask

	// Send the first len characters of the record buffer.
	task automatic send_record(input logic first, input int len);
		int i;
		for (i = 0; i < len; i++) begin
			send_char(rec_buf[i], first && i == 0);
		end
	endtask

	task automatic load_record(input string text);
		int p;
		for (p = 0; p < slrp_pkg::RecLen; p++) begin
			rec_buf[p] = text[p];
		end
	endtask

	// Fill the buffer with a well-formed record of random content, with optional noise.
	task automatic build_record(input int noise_pct);
		string frame;
		int p;
		int r;
		frame = "0000-00-00T00:00:00 ";
		for (p = 0; p < slrp_pkg::RecLen; p++) begin
			if (p < 20 && frame[p] != "0") begin
				rec_buf[p] = frame[p];
			end else if (p < 20) begin
				rec_buf[p] = 8'h30 + 8'($urandom_range(0, 9));
			end else begin
				r = $urandom_range(0, 21);
				if (r < 10) begin
					rec_buf[p] = 8'h30 + 8'(r);
				end else if (r < 16) begin
					rec_buf[p] = 8'h61 + 8'(r - 10);
				end else begin
					rec_buf[p] = 8'h41 + 8'(r - 16);
				end
			end
			if ($urandom_range(0, 99) < noise_pct) begin
				rec_buf[p] = 8'($urandom);
			end
		end
	endtask

	// Stop offering and wait until every awaited record has arrived.
	task automatic wait_results_drained;
		s_tvalid <= 1'b0;
		while (expected_records.size() != 0) @(posedge clk);
		repeat (TailCycles) @(posedge clk);
	endtask

	// Take each result transfer and compare it with the oldest awaited record.
	initial begin : receiver
		int gap;
		slrp_pkg::record_t want;
		logic [slrp_pkg::OutDataW-1:0] got;
		m_tready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (rx_hold_cycles > 0) begin
				gap = rx_hold_cycles;
				rx_hold_cycles = 0;
			end else begin
				gap = rx_idle_en ? $urandom_range(0, 5) : 0;
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got = m_tdata;
			if (expected_records.size() == 0) begin
				report_error($sformatf("result with no record awaited: %h", got));
			end else begin
				want = expected_records.pop_front();
				compare_field("year", got[13:0], want.year);
				compare_field("month", got[20:14], want.month);
				compare_field("day", got[27:21], want.day);
				compare_field("hour", got[34:28], want.hour);
				compare_field("minute", got[41:35], want.minute);
				compare_field("second", got[48:42], want.second);
				compare_field("battery_level", got[61:49], want.battery_level);
				compare_field("temperature_tenths", got[77:62], want.temperature_tenths);
				compare_field("humidity_tenths", got[93:78], want.humidity_tenths);
				compare_field("padding", got[95:94], 0);
				records_checked++;
			end
		end
	end

	// Extreme values, both hex cases, chaining without a marker, and non-digit characters.
	task automatic test_directed_records;
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		load_record("0000-00-00T00:00:00 0000000000");
		send_record(1'b1, slrp_pkg::RecLen);
		load_record("9999-99-99T99:99:99 FFFFFFFFFF");
		send_record(1'b0, slrp_pkg::RecLen);
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		load_record("2023-12-31T23:59:58 7fffff8000");
		send_record(1'b1, slrp_pkg::RecLen);
		load_record("1970-01-01T00:00:01 aBcDeF0123");
		send_record(1'b0, slrp_pkg::RecLen);
		// Characters just outside the digit ranges, plus all-zero and all-one bytes.
		load_record("/:A9-:/-9:Ta0: 5:x~ G@Hg/:FfAa");
		rec_buf[0] = 8'h00;
		rec_buf[1] = 8'hFF;
		rec_buf[4] = 8'hFF;
		rec_buf[19] = 8'h00;
		rec_buf[20] = 8'hFF;
		rec_buf[22] = 8'h60;
		rec_buf[25] = 8'h00;
		send_record(1'b1, slrp_pkg::RecLen);
		wait_results_drained();
	endtask

	// Records cut short at various points, then restarted by the line-start marker.
	task automatic test_realignment;
		int n;
		int len;
		for (n = 0; n < 8; n++) begin
			build_record(0);
			if (n == 0) begin
				len = slrp_pkg::RecLen - 1;
			end else if (n == 1) begin
				len = 1;
			end else begin
				len = $urandom_range(1, slrp_pkg::RecLen - 1);
			end
			send_record(n[0], len);
			build_record(0);
			send_record(1'b1, slrp_pkg::RecLen);
		end
		wait_results_drained();
	endtask

	// The receiver holds off while the sender keeps offering, so the input stalls.
	task automatic test_output_backpressure;
		int n;
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		rx_hold_cycles = StallCycles;
		for (n = 0; n < 4; n++) begin
			build_record(0);
			send_record(n == 0, slrp_pkg::RecLen);
		end
		wait_results_drained();
	endtask

	// Mostly well-formed records, with noisy and truncated ones, stray bytes and pauses.
	task automatic test_random_traffic;
		int target;
		int r;
		int k;
		int len;
		target = chars_sent + RandomChars;
		while (chars_sent < target) begin
			tx_idle_en = $urandom_range(0, 3) != 0;
			rx_idle_en = $urandom_range(0, 3) != 0;
			r = $urandom_range(0, 99);
			if (r < 65) begin
				build_record(0);
				send_record(1'($urandom_range(0, 1)), slrp_pkg::RecLen);
			end else if (r < 80) begin
				build_record(10);
				send_record(1'($urandom_range(0, 1)), slrp_pkg::RecLen);
			end else if (r < 90) begin
				build_record(0);
				send_record(1'b1, $urandom_range(1, slrp_pkg::RecLen - 1));
			end else if (r < 97) begin
				len = $urandom_range(1, 8);
				for (k = 0; k < len; k++) begin
					send_char(8'($urandom), $urandom_range(0, 7) == 0);
				end
			end else begin
				wait_results_drained();
			end
		end
		wait_results_drained();
	endtask

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_records();
		test_realignment();
		test_output_backpressure();
		test_random_traffic();

		$display("Sent %0d characters with %0d line-start marks and checked %0d records.",
			chars_sent, line_starts, records_checked);
		$display("Covered extremes, non-digits, realignment, a %0d-cycle output stall %s",
			StallCycles, "and random traffic.");
		if (error_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
